FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked on every rising edge outside reset
`define ASSERT_ALWAYS(lbl, clk_i, rst_n_i, prop_i) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (prop_i)) \
		else $error("assertion failed: lbl");
// Same-cycle implication
`define ASSERT_IMPLY(lbl, clk_i, rst_n_i, ante_i, cons_i) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante_i) |-> (cons_i)) \
		else $error("assertion failed: lbl");
`else
`define ASSERT_ALWAYS(lbl, clk_i, rst_n_i, prop_i)
`define ASSERT_IMPLY(lbl, clk_i, rst_n_i, ante_i, cons_i)
`endif

`endif

FILE: rtl/core/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// Types, register indexes and constants of the line trace steering block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lts_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_PERIOD  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WARMUP_TICKS  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_END_THRESHOLD = 3'd6;

	// reset values
	localparam logic [9:0]  RST_SETPOINT      = 10'd555;
	localparam logic [15:0] RST_PROP_GAIN     = 16'd384;
	localparam logic [15:0] RST_INTEG_GAIN    = 16'd66;
	localparam logic [19:0] RST_DERIV_GAIN    = 20'd25600;
	localparam logic [15:0] RST_CLEAR_PERIOD  = 16'd250;
	localparam logic [15:0] RST_WARMUP_TICKS  = 16'd250;
	localparam logic [9:0]  RST_END_THRESHOLD = 10'd610;

	// pair sum saturation limits (22-bit signed)
	localparam logic signed [23:0] PAIR_SUM_MAX = 24'sd2097151;
	localparam logic signed [23:0] PAIR_SUM_MIN = -24'sd2097152;

	// steering and speed
	localparam logic signed [44:0] TURN_LIMIT_W = 45'sd100;
	localparam logic signed [7:0]  TURN_MAX     = 8'sd100;
	localparam logic signed [7:0]  TURN_MIN     = -8'sd100;
	localparam logic [6:0] GENTLE_TURN    = 7'd30;
	localparam logic [6:0] MODERATE_TURN  = 7'd50;
	localparam logic [6:0] SPEED_WARMUP   = 7'd50;
	localparam logic [6:0] SPEED_STRAIGHT = 7'd100;
	localparam logic [6:0] SPEED_CURVE    = 7'd90;
	localparam logic [6:0] SPEED_SHARP    = 7'd85;

	typedef struct packed {
		logic [9:0]  setpoint;
		logic [15:0] prop_gain_q8;
		logic [15:0] integ_gain_q16;
		logic [19:0] deriv_gain_q8;
		logic [15:0] integ_clear_period;
		logic [15:0] warmup_ticks;
		logic [9:0]  end_threshold;
	} cfg_t;

	// products and flags handed from the error stage to the steering stage
	typedef struct packed {
		logic signed [27:0] p_term;
		logic signed [38:0] i_term;
		logic signed [32:0] d_term;
		logic               past;
		logic               line_end;
	} terms_t;

endpackage

FILE: rtl/core/lts_cfg_regs.sv
// ----------------------------------------------------------------------------
// lts_cfg_regs
// Configuration register file; writes keep only each register's width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lts_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lts_pkg::CFG_DATA_W-1:0]  cfg_data,
	output lts_pkg::cfg_t                   cfg
);
	import lts_pkg::*;

	cfg_t cfg_q;

	// register writes; unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint           <= RST_SETPOINT;
			cfg_q.prop_gain_q8       <= RST_PROP_GAIN;
			cfg_q.integ_gain_q16     <= RST_INTEG_GAIN;
			cfg_q.deriv_gain_q8      <= RST_DERIV_GAIN;
			cfg_q.integ_clear_period <= RST_CLEAR_PERIOD;
			cfg_q.warmup_ticks       <= RST_WARMUP_TICKS;
			cfg_q.end_threshold      <= RST_END_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SETPOINT:      cfg_q.setpoint           <= cfg_data[9:0];
				REG_PROP_GAIN:     cfg_q.prop_gain_q8       <= cfg_data[15:0];
				REG_INTEG_GAIN:    cfg_q.integ_gain_q16     <= cfg_data[15:0];
				REG_DERIV_GAIN:    cfg_q.deriv_gain_q8      <= cfg_data[19:0];
				REG_CLEAR_PERIOD:  cfg_q.integ_clear_period <= cfg_data[15:0];
				REG_WARMUP_TICKS:  cfg_q.warmup_ticks       <= cfg_data[15:0];
				REG_END_THRESHOLD: cfg_q.end_threshold      <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/lts_err_stage.sv
// ----------------------------------------------------------------------------
// lts_err_stage
// Error, pair sum and tick counters; forms the three PID products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lts_err_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic [9:0]     light_s1,
	input  lts_pkg::cfg_t  cfg,
	output lts_pkg::terms_t terms_s2
);
	import lts_pkg::*;

	logic signed [10:0] prev_error_q;
	logic signed [21:0] pair_sum_q;
	logic [15:0]        clear_cnt_q;
	logic [15:0]        warmup_cnt_q;

	logic signed [10:0] err;
	logic signed [11:0] diff;
	logic [16:0]        next_count;
	logic               clear;
	logic signed [21:0] pair_base;
	logic signed [23:0] pair_raw;
	logic signed [21:0] pair_new;
	logic signed [27:0] p_prod;
	logic signed [38:0] i_prod;
	logic signed [32:0] d_prod;
	logic               past;

	// error and periodic clear of the pair sum
	always_comb begin
		err        = $signed({1'b0, light_s1}) - $signed({1'b0, cfg.setpoint});
		diff       = 12'(err) - 12'(prev_error_q);
		next_count = {1'b0, clear_cnt_q} + 17'd1;
		clear      = next_count > {1'b0, cfg.integ_clear_period};
		pair_base  = clear ? '0 : pair_sum_q;
	end

	// trapezoid step with saturation
	always_comb begin
		pair_raw = 24'(pair_base) + 24'(err) + 24'(prev_error_q);
		if (pair_raw > PAIR_SUM_MAX)
			pair_new = PAIR_SUM_MAX[21:0];
		else if (pair_raw < PAIR_SUM_MIN)
			pair_new = PAIR_SUM_MIN[21:0];
		else
			pair_new = pair_raw[21:0];
	end

	// gain products; gains are unsigned, widened by a zero sign bit
	always_comb begin
		p_prod = $signed({1'b0, cfg.prop_gain_q8}) * err;
		i_prod = $signed({1'b0, cfg.integ_gain_q16}) * pair_new;
		d_prod = $signed({1'b0, cfg.deriv_gain_q8}) * diff;
		past   = warmup_cnt_q >= cfg.warmup_ticks;
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			pair_sum_q   <= '0;
			clear_cnt_q  <= '0;
			warmup_cnt_q <= '0;
		end else if (en) begin
			prev_error_q <= err;
			pair_sum_q   <= pair_new;
			clear_cnt_q  <= clear ? '0 : next_count[15:0];
			if (warmup_cnt_q != 16'hFFFF)
				warmup_cnt_q <= warmup_cnt_q + 16'd1;
		end
	end

	// stage register
	always_ff @(posedge clk) begin
		if (en) begin
			terms_s2.p_term   <= p_prod;
			terms_s2.i_term   <= i_prod;
			terms_s2.d_term   <= d_prod;
			terms_s2.past     <= past;
			terms_s2.line_end <= past && (light_s1 > cfg.end_threshold);
		end
	end

endmodule

FILE: rtl/core/lts_steer_stage.sv
// ----------------------------------------------------------------------------
// lts_steer_stage
// Sums the PID terms at Q16, negates, truncates, clamps; picks the speed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lts_steer_stage (
	input  logic              clk,
	input  logic              en,
	input  lts_pkg::terms_t   terms_s2,
	output logic signed [7:0] turn,
	output logic [6:0]        forward,
	output logic              line_end
);
	import lts_pkg::*;

	logic signed [43:0] acc;
	logic signed [44:0] neg;
	logic signed [44:0] quo;
	logic signed [7:0]  turn_c;
	logic signed [7:0]  turn_abs;
	logic [6:0]         mag;
	logic [6:0]         speed;

	// common Q16 sum, negated
	always_comb begin
		acc = (44'(terms_s2.p_term) <<< 8) + 44'(terms_s2.i_term)
			+ (44'(terms_s2.d_term) <<< 8);
		neg = -(45'(acc));
	end

	// divide by 2^16 toward zero, then clamp
	always_comb begin
		quo = neg >>> 16;
		if (neg[44] && (|neg[15:0]))
			quo = quo + 45'sd1;
		if (quo > TURN_LIMIT_W)
			turn_c = TURN_MAX;
		else if (quo < -TURN_LIMIT_W)
			turn_c = TURN_MIN;
		else
			turn_c = quo[7:0];
	end

	// speed by turn size, or the warm-up speed until warm-up is past
	always_comb begin
		turn_abs = turn_c[7] ? -turn_c : turn_c;
		mag      = turn_abs[6:0];
		if (!terms_s2.past)
			speed = SPEED_WARMUP;
		else if (mag < GENTLE_TURN)
			speed = SPEED_STRAIGHT;
		else if (mag < MODERATE_TURN)
			speed = SPEED_CURVE;
		else
			speed = SPEED_SHARP;
	end

	// result register
	always_ff @(posedge clk) begin
		if (en) begin
			turn     <= turn_c;
			forward  <= speed;
			line_end <= terms_s2.line_end;
		end
	end

endmodule

FILE: rtl/core/line_trace_pid_steering.sv
// ----------------------------------------------------------------------------
// line_trace_pid_steering
// PID line-follower steering with forward speed and line-end flag.
// ----------------------------------------------------------------------------
// One light sample word is accepted per clock while in_stall is low; each
// gives one result word (turn, forward, line_end) through the input, error
// stage and result registers. The rate is one word per cycle while no stall
// holds the flow, set by the update of the controller state (previous error,
// pair sum, clear and warm-up counters) in the error stage; a stall on the
// output backs up through three registered stages before the input stalls.
// Configuration writes take effect on the next clock.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module line_trace_pid_steering (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lts_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [9:0]                      light,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [7:0]               turn,
	output logic [6:0]                      forward,
	output logic                            line_end
);
	import lts_pkg::*;

	cfg_t   cfg;
	terms_t terms_s2;

	logic       valid_s1;
	logic       valid_s2;
	logic       valid_q;
	logic [9:0] light_s1;
	logic       adv_s2;
	logic       adv_out;
	logic       accept;

	// pipeline flow control
	always_comb begin
		adv_out  = valid_s2 && (!valid_q || !out_stall);
		adv_s2   = valid_s1 && (!valid_s2 || adv_out);
		in_stall = valid_s1 && !adv_s2;
		accept   = in_valid && !in_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (adv_s2)
				valid_s1 <= 1'b0;
			if (adv_s2)
				valid_s2 <= 1'b1;
			else if (adv_out)
				valid_s2 <= 1'b0;
			if (adv_out)
				valid_q <= 1'b1;
			else if (!out_stall)
				valid_q <= 1'b0;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (accept)
			light_s1 <= light;
	end

	lts_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lts_err_stage u_err (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv_s2),
		.light_s1 (light_s1),
		.cfg      (cfg),
		.terms_s2 (terms_s2)
	);

	lts_steer_stage u_steer (
		.clk      (clk),
		.en       (adv_out),
		.terms_s2 (terms_s2),
		.turn     (turn),
		.forward  (forward),
		.line_end (line_end)
	);

	assign out_valid = valid_q;

	// checks
	`ASSERT_IMPLY(a_turn_range, clk, arst_n, out_valid,
		(turn <= TURN_MAX) && (turn >= TURN_MIN))
	`ASSERT_IMPLY(a_speed_code, clk, arst_n, out_valid,
		(forward == SPEED_WARMUP) || (forward == SPEED_STRAIGHT) ||
		(forward == SPEED_CURVE) || (forward == SPEED_SHARP))
	`ASSERT_IMPLY(a_end_after_warmup, clk, arst_n, out_valid && line_end,
		forward != SPEED_WARMUP)
	`ASSERT_ALWAYS(a_stall_only_full, clk, arst_n,
		!in_stall || (valid_s1 && valid_s2 && valid_q && out_stall))

endmodule
